FILE: rtl/abfc_pkg.sv
// ----------------------------------------------------------------------------
// abfc_pkg: shared definitions for the bitstream format converter
// Format codes, conversion step kinds, the decoded mode struct and the
// intermediate byte type that travels between the front and back parts.
// ----------------------------------------------------------------------------
package abfc_pkg;

    // Stream format codes
    localparam logic [2:0] FMT_BYTES = 3'd0;
    localparam logic [2:0] FMT_BE16  = 3'd1;
    localparam logic [2:0] FMT_LE16  = 3'd2;
    localparam logic [2:0] FMT_BE14  = 3'd3;
    localparam logic [2:0] FMT_LE14  = 3'd4;

    // Step performed on the input side
    localparam logic [1:0] PRE_NONE   = 2'd0;
    localparam logic [1:0] PRE_SWAP   = 2'd1;
    localparam logic [1:0] PRE_UNPACK = 2'd2;

    // Step performed on the output side
    localparam logic [1:0] POST_NONE = 2'd0;
    localparam logic [1:0] POST_SWAP = 2'd1;
    localparam logic [1:0] POST_PACK = 2'd2;

    // Register indexes on the configuration port
    localparam logic REG_SOURCE = 1'b0;
    localparam logic REG_TARGET = 1'b1;

    // Default depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic       valid;
        logic [1:0] pre_kind;
        logic       pre_le;
        logic [1:0] post_kind;
        logic       post_le;
    } mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } ibyte_t;

    // Map a source/target format pair to the chain of steps
    function automatic mode_t decode_mode(input logic [2:0] src, input logic [2:0] tgt);
        mode_t m;
        m           = '0;
        m.valid     = (src <= FMT_LE14) && (tgt <= FMT_LE14);
        m.pre_le    = (src == FMT_LE14);
        m.post_le   = (tgt == FMT_LE14);
        m.pre_kind  = PRE_NONE;
        m.post_kind = POST_NONE;
        if (src <= FMT_BE16) begin
            if (tgt == FMT_LE16) begin
                m.post_kind = POST_SWAP;
            end else if (tgt >= FMT_BE14) begin
                m.post_kind = POST_PACK;
            end
        end else if (src == FMT_LE16) begin
            if (tgt <= FMT_BE16) begin
                m.post_kind = POST_SWAP;
            end else if (tgt >= FMT_BE14) begin
                m.pre_kind  = PRE_SWAP;
                m.post_kind = POST_PACK;
            end
        end else begin
            if (tgt <= FMT_BE16) begin
                m.pre_kind = PRE_UNPACK;
            end else if (tgt == FMT_LE16) begin
                m.pre_kind  = PRE_UNPACK;
                m.post_kind = POST_SWAP;
            end else if (tgt != src) begin
                m.post_kind = POST_SWAP;
            end
        end
        return m;
    endfunction

    // Bytes emitted for a packed group holding cnt input bytes
    function automatic logic [3:0] pack_len(input logic [3:0] cnt);
        logic [3:0] n;
        case (cnt)
            4'd1: n = 4'd2;
            4'd2: n = 4'd4;
            4'd3: n = 4'd4;
            4'd4: n = 4'd6;
            4'd5: n = 4'd6;
            4'd6: n = 4'd8;
            4'd7: n = 4'd8;
            default: n = 4'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: rtl/abfc_front.sv
// ----------------------------------------------------------------------------
// abfc_front: input side of the converter
// Accepts frame bytes, applies the byte pair swap or 14-bit unpack step and
// feeds the resulting intermediate bytes, one per cycle while the queue accepts them, to the queue.
// ----------------------------------------------------------------------------
module abfc_front
    import abfc_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   flush,
    input  mode_t  mode,
    input  logic   in_valid,
    output logic   in_ready,
    input  ibyte_t in_item,
    output logic   out_valid,
    input  logic   out_ready,
    output ibyte_t out_item
);

    logic [7:0]  grp_reg [8];
    logic [2:0]  fill_reg, fill_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic        held_valid_reg, held_valid_next;
    logic [55:0] emit_data_reg, emit_data_next;
    logic [2:0]  emit_cnt_reg, emit_cnt_next;
    logic        emit_last_reg, emit_last_next;

    logic [3:0]  grp_cnt;
    logic [7:0]  grp_bytes [8];
    logic [55:0] unpacked;
    logic [2:0]  unpack_len;
    logic        produce;
    logic        emit_free;
    logic        accept;
    logic        take;

    assign grp_cnt    = {1'b0, fill_reg} + 4'd1;
    assign unpack_len = (grp_cnt == 4'd8) ? 3'd7 : grp_cnt[2:0];

    // Merge the stored group with the incoming byte, zero padded
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            if (3'(j) < fill_reg) begin
                grp_bytes[j] = grp_reg[j];
            end else if (3'(j) == fill_reg) begin
                grp_bytes[j] = in_item.data;
            end else begin
                grp_bytes[j] = 8'h00;
            end
        end
    end

    // Keep the low 14 bits of each word and join them into 56 bits
    always_comb begin
        logic [15:0] word;
        word     = '0;
        unpacked = '0;
        for (int w = 0; w < 4; w++) begin
            word = mode.pre_le ? {grp_bytes[2*w+1], grp_bytes[2*w]}
                               : {grp_bytes[2*w], grp_bytes[2*w+1]};
            unpacked[55-14*w -: 14] = word[13:0];
        end
    end

    // Decide whether this byte releases output
    always_comb begin
        case (mode.pre_kind)
            PRE_SWAP:   produce = mode.valid && (held_valid_reg || in_item.last);
            PRE_UNPACK: produce = mode.valid && ((grp_cnt == 4'd8) || in_item.last);
            default:    produce = mode.valid;
        endcase
    end

    assign emit_free = (emit_cnt_reg == 3'd0) || ((emit_cnt_reg == 3'd1) && out_ready);
    assign in_ready  = !produce || emit_free;
    assign accept    = in_valid && in_ready;

    assign out_valid     = (emit_cnt_reg != 3'd0);
    assign out_item.data = emit_data_reg[55:48];
    assign out_item.last = emit_last_reg && (emit_cnt_reg == 3'd1);
    assign take          = out_valid && out_ready;

    // Advance the emit register and load new requests
    always_comb begin
        fill_next       = fill_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        emit_data_next  = emit_data_reg;
        emit_cnt_next   = emit_cnt_reg;
        emit_last_next  = emit_last_reg;
        if (take) begin
            emit_data_next = emit_data_reg << 8;
            emit_cnt_next  = emit_cnt_reg - 3'd1;
        end
        if (accept && mode.valid) begin
            case (mode.pre_kind)
                PRE_SWAP: begin
                    if (held_valid_reg) begin
                        emit_data_next  = {in_item.data, held_byte_reg, 40'h0};
                        emit_cnt_next   = 3'd2;
                        emit_last_next  = in_item.last;
                        held_valid_next = 1'b0;
                    end else if (in_item.last) begin
                        emit_data_next = {8'h00, in_item.data, 40'h0};
                        emit_cnt_next  = 3'd2;
                        emit_last_next = 1'b1;
                    end else begin
                        held_byte_next  = in_item.data;
                        held_valid_next = 1'b1;
                    end
                end
                PRE_UNPACK: begin
                    if (produce) begin
                        emit_data_next = unpacked;
                        emit_cnt_next  = unpack_len;
                        emit_last_next = in_item.last;
                        fill_next      = 3'd0;
                    end else begin
                        fill_next = grp_cnt[2:0];
                    end
                end
                default: begin
                    emit_data_next = {in_item.data, 48'h0};
                    emit_cnt_next  = 3'd1;
                    emit_last_next = in_item.last;
                end
            endcase
        end
        // Drop any frame in progress on a register write
        if (flush) begin
            fill_next       = 3'd0;
            held_valid_next = 1'b0;
            emit_cnt_next   = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= 3'd0;
            held_byte_reg  <= 8'h00;
            held_valid_reg <= 1'b0;
            emit_cnt_reg   <= 3'd0;
            emit_last_reg  <= 1'b0;
        end else begin
            fill_reg       <= fill_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            emit_cnt_reg   <= emit_cnt_next;
            emit_last_reg  <= emit_last_next;
        end
    end

    // Payload: emit data and group bytes
    always_ff @(posedge aclk) begin
        emit_data_reg <= emit_data_next;
        if (accept && mode.valid && (mode.pre_kind == PRE_UNPACK)) begin
            grp_reg[fill_reg] <= in_item.data;
        end
    end

endmodule

FILE: rtl/abfc_fifo.sv
// ----------------------------------------------------------------------------
// abfc_fifo: short queue of intermediate bytes
// Decouples the front and back parts so that each can stall on its own.
// ----------------------------------------------------------------------------
module abfc_fifo
    import abfc_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   flush,
    input  logic   push_valid,
    output logic   push_ready,
    input  ibyte_t push_item,
    output logic   pop_valid,
    input  logic   pop_ready,
    output ibyte_t pop_item
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ibyte_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers with wrap at the queue depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
        if (flush) begin
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            count_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed request
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/abfc_back.sv
// ----------------------------------------------------------------------------
// abfc_back: output side of the converter
// Takes intermediate bytes from the queue, applies the pair swap or 14-bit
// pack step and drives the result bytes from its output register.
// ----------------------------------------------------------------------------
module abfc_back
    import abfc_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   flush,
    input  mode_t  mode,
    input  logic   in_valid,
    output logic   in_ready,
    input  ibyte_t in_item,
    output logic   out_valid,
    input  logic   out_ready,
    output ibyte_t out_item
);

    logic [7:0]  grp_reg [7];
    logic [2:0]  fill_reg, fill_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic        held_valid_reg, held_valid_next;
    logic [63:0] emit_data_reg, emit_data_next;
    logic [3:0]  emit_cnt_reg, emit_cnt_next;
    logic        emit_last_reg, emit_last_next;

    logic [3:0]  grp_cnt;
    logic [55:0] grp_bits;
    logic [63:0] packed_out;
    logic [3:0]  pack_n;
    logic        produce;
    logic        emit_free;
    logic        accept;
    logic        take;

    assign grp_cnt = {1'b0, fill_reg} + 4'd1;
    assign pack_n  = pack_len(grp_cnt);

    // Merge the stored group with the incoming byte, zero padded
    always_comb begin
        for (int j = 0; j < 7; j++) begin
            if (3'(j) < fill_reg) begin
                grp_bits[55-8*j -: 8] = grp_reg[j];
            end else if (3'(j) == fill_reg) begin
                grp_bits[55-8*j -: 8] = in_item.data;
            end else begin
                grp_bits[55-8*j -: 8] = 8'h00;
            end
        end
    end

    // Split 56 bits into four 14-bit words, each in a 16-bit slot
    always_comb begin
        logic [13:0] word;
        word       = '0;
        packed_out = '0;
        for (int w = 0; w < 4; w++) begin
            word = grp_bits[55-14*w -: 14];
            packed_out[63-16*w -: 16] = mode.post_le ? {word[7:0], 2'b00, word[13:8]}
                                                     : {2'b00, word};
        end
    end

    // Decide whether this byte releases output
    always_comb begin
        case (mode.post_kind)
            POST_SWAP: produce = held_valid_reg || in_item.last;
            POST_PACK: produce = (grp_cnt == 4'd7) || in_item.last;
            default:   produce = 1'b1;
        endcase
    end

    assign emit_free = (emit_cnt_reg == 4'd0) || ((emit_cnt_reg == 4'd1) && out_ready);
    assign in_ready  = !produce || emit_free;
    assign accept    = in_valid && in_ready;

    assign out_valid     = (emit_cnt_reg != 4'd0);
    assign out_item.data = emit_data_reg[63:56];
    assign out_item.last = emit_last_reg && (emit_cnt_reg == 4'd1);
    assign take          = out_valid && out_ready;

    // Advance the output register and load new requests
    always_comb begin
        fill_next       = fill_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        emit_data_next  = emit_data_reg;
        emit_cnt_next   = emit_cnt_reg;
        emit_last_next  = emit_last_reg;
        if (take) begin
            emit_data_next = emit_data_reg << 8;
            emit_cnt_next  = emit_cnt_reg - 4'd1;
        end
        if (accept) begin
            case (mode.post_kind)
                POST_SWAP: begin
                    if (held_valid_reg) begin
                        emit_data_next  = {in_item.data, held_byte_reg, 48'h0};
                        emit_cnt_next   = 4'd2;
                        emit_last_next  = in_item.last;
                        held_valid_next = 1'b0;
                    end else if (in_item.last) begin
                        emit_data_next = {8'h00, in_item.data, 48'h0};
                        emit_cnt_next  = 4'd2;
                        emit_last_next = 1'b1;
                    end else begin
                        held_byte_next  = in_item.data;
                        held_valid_next = 1'b1;
                    end
                end
                POST_PACK: begin
                    if (produce) begin
                        emit_data_next = packed_out;
                        emit_cnt_next  = pack_n;
                        emit_last_next = in_item.last;
                        fill_next      = 3'd0;
                    end else begin
                        fill_next = grp_cnt[2:0];
                    end
                end
                default: begin
                    emit_data_next = {in_item.data, 56'h0};
                    emit_cnt_next  = 4'd1;
                    emit_last_next = in_item.last;
                end
            endcase
        end
        // Drop any frame in progress on a register write
        if (flush) begin
            fill_next       = 3'd0;
            held_valid_next = 1'b0;
            emit_cnt_next   = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= 3'd0;
            held_byte_reg  <= 8'h00;
            held_valid_reg <= 1'b0;
            emit_cnt_reg   <= 4'd0;
            emit_last_reg  <= 1'b0;
        end else begin
            fill_reg       <= fill_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            emit_cnt_reg   <= emit_cnt_next;
            emit_last_reg  <= emit_last_next;
        end
    end

    // Payload: output data and group bytes
    always_ff @(posedge aclk) begin
        emit_data_reg <= emit_data_next;
        if (accept && (mode.post_kind == POST_PACK)) begin
            grp_reg[fill_reg] <= in_item.data;
        end
    end

endmodule

FILE: rtl/audio_bitstream_format_converter_core.sv
// A result byte passes through the front emit register, the queue and the back output
// register. One byte per cycle on each side while neither side stalls; a pack group
// gives 8 bytes per 7 in, so there the single output register holds the input back.
// Unpack releases 7 bytes per 8 in, one per cycle from the front emit register.
// Reset (aresetn low, synchronous) sets both formats to plain bytes and empties
// the group, pair, queue and output state; group byte storage is not cleared.
// ----------------------------------------------------------------------------
// audio_bitstream_format_converter_core: audio bitstream format converter
// Converts a byte stream between plain, 16-bit BE/LE and 14-in-16-bit BE/LE
// formats. A front part unpacks or swaps, a queue decouples, a back part
// packs or swaps and drives the result stream.
// ----------------------------------------------------------------------------
module audio_bitstream_format_converter_core
    import abfc_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [2:0] source_format_reg;
    logic [2:0] target_format_reg;
    logic       cfg_wr;
    mode_t      mode;

    ibyte_t     in_item;
    ibyte_t     q_push_item;
    logic       q_push_valid;
    logic       q_push_ready;
    ibyte_t     q_pop_item;
    logic       q_pop_valid;
    logic       q_pop_ready;
    ibyte_t     out_item;

    // Register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_format_reg <= FMT_BYTES;
            target_format_reg <= FMT_BYTES;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_SOURCE: source_format_reg <= pwdata[2:0];
                REG_TARGET: target_format_reg <= pwdata[2:0];
                default:    source_format_reg <= source_format_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SOURCE: prdata = 32'(source_format_reg);
            REG_TARGET: prdata = 32'(target_format_reg);
            default:    prdata = 32'h0;
        endcase
    end

    assign mode = decode_mode(source_format_reg, target_format_reg);

    assign in_item.data = s_tdata;
    assign in_item.last = s_tlast;

    abfc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .flush     (cfg_wr),
        .mode      (mode),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (q_push_valid),
        .out_ready (q_push_ready),
        .out_item  (q_push_item)
    );

    abfc_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .flush      (cfg_wr),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_item  (q_push_item),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_item   (q_pop_item)
    );

    abfc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .flush     (cfg_wr),
        .mode      (mode),
        .in_valid  (q_pop_valid),
        .in_ready  (q_pop_ready),
        .in_item   (q_pop_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = out_item.data;
    assign m_tlast = out_item.last;

    // Reset leaves no result pending
    a_reset_clears_output: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result stream valid after reset");

    // A register write empties the queue
    a_write_flushes_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> !q_pop_valid)
        else $error("queue not empty after register write");

    // An unknown format never sends a byte into the queue
    a_bad_format_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        !mode.valid |-> !q_push_valid)
        else $error("queue request under an unknown format");

endmodule

FILE: tb/sv/tb_audio_bitstream_format_converter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_audio_bitstream_format_converter_core: converter core self-checking bench
// Streams byte frames through every source/target format pair, predicts the
// converted bytes (pack, unpack, pair swap, frame tails) in the bench and
// compares each result byte and its tlast flag in order. Covers unknown
// format codes, register read-back, idle gaps on both sides and a long
// output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_audio_bitstream_format_converter_core;
    import abfc_pkg::*;

    localparam int          CYCLE_LIMIT      = 300000;
    localparam int          CONFIG_ITEMS     = 6;
    localparam int          SETTLE_CYCLES    = 10;
    localparam int          MAX_PER_REQUEST  = 10;
    localparam int          MAX_PRINTS       = 60;
    localparam logic [2:0]  FMT_UNUSED_FIRST = 3'd5;
    localparam logic [2:0]  FMT_UNUSED_LAST  = 3'd7;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] in_byte
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;            // [7:0] out_byte
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Predicted converter state
    logic [2:0]  src_fmt    = FMT_BYTES;
    logic [2:0]  tgt_fmt    = FMT_BYTES;
    logic [7:0]  grp_buf [8];
    logic [2:0]  grp_fill   = 3'd0;
    logic [7:0]  held_byte  = 8'h00;
    logic        held_valid = 1'b0;
    logic [1:0]  pre_step;
    logic [1:0]  post_step;
    logic        src_le;
    logic        tgt_le;
    int          step_results;

    ibyte_t      bytes_due[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          items_sent     = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;
    int          stall_left     = 0;

    audio_bitstream_format_converter_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Conversion predictor
    // ------------------------------------------------------------------

    // Record one converted byte; a single request yields at most ten
    function automatic void queue_byte(input logic [7:0] b, input logic is_last);
        ibyte_t e;
        if (step_results < MAX_PER_REQUEST) begin
            e.data = b;
            e.last = is_last;
            bytes_due.push_back(e);
        end
        step_results++;
    endfunction

    // Collect 7 bytes, emit them as four 14-bit words; a tail emits only
    // the words that hold its bits
    function automatic void pack_byte(input logic [7:0] b, input logic is_last);
        int          cnt;
        int          n;
        logic [55:0] bits;
        logic [13:0] w;
        logic        hi;
        cnt = grp_fill + 1;
        grp_buf[cnt - 1] = b;
        if (cnt < 7 && !is_last) begin
            grp_fill = 3'(cnt);
            return;
        end
        for (int j = cnt; j < 7; j++) grp_buf[j] = 8'h00;
        bits = '0;
        for (int j = 0; j < 7; j++) bits = {bits[47:0], grp_buf[j]};
        n = 2 * (cnt / 2) + 2;
        for (int k = 0; k < n; k++) begin
            w  = 14'(bits >> (42 - 14 * (k / 2)));
            hi = ((k % 2) == 0) != tgt_le;
            queue_byte(hi ? {2'b00, w[13:8]} : w[7:0], is_last && (k + 1 == n));
        end
        grp_fill = 3'd0;
    endfunction

    // Collect 8 bytes (four words), keep 14 bits of each, emit 7 bytes;
    // a tail of r bytes is zero padded and emits r bytes
    function automatic void unpack_byte(input logic [7:0] b, input logic is_last);
        int          cnt;
        int          n;
        logic [7:0]  first_b;
        logic [7:0]  second_b;
        logic [15:0] w;
        logic [55:0] bits;
        cnt = grp_fill + 1;
        grp_buf[cnt - 1] = b;
        if (cnt < 8 && !is_last) begin
            grp_fill = 3'(cnt);
            return;
        end
        bits = '0;
        for (int j = 0; j < 4; j++) begin
            first_b  = (2 * j < cnt) ? grp_buf[2 * j] : 8'h00;
            second_b = (2 * j + 1 < cnt) ? grp_buf[2 * j + 1] : 8'h00;
            w        = src_le ? {second_b, first_b} : {first_b, second_b};
            bits     = {bits[41:0], w[13:0]};
        end
        n = (cnt >= 8) ? 7 : cnt;
        for (int j = 0; j < n; j++) post_byte(bits[55 - 8 * j -: 8], is_last && (j + 1 == n));
        grp_fill = 3'd0;
    endfunction

    function automatic void swap_out(input logic [7:0] b, input logic is_last);
        if (pre_step == PRE_SWAP) pack_byte(b, is_last);
        else queue_byte(b, is_last);
    endfunction

    // Swap bytes in pairs; an odd byte at frame end pairs with a zero
    function automatic void swap_byte(input logic [7:0] b, input logic is_last);
        if (held_valid) begin
            swap_out(b, 1'b0);
            swap_out(held_byte, is_last);
            held_valid = 1'b0;
        end else if (is_last) begin
            swap_out(8'h00, 1'b0);
            swap_out(b, 1'b1);
        end else begin
            held_byte  = b;
            held_valid = 1'b1;
        end
    endfunction

    function automatic void post_byte(input logic [7:0] b, input logic is_last);
        case (post_step)
            POST_SWAP: swap_byte(b, is_last);
            POST_PACK: pack_byte(b, is_last);
            default:   queue_byte(b, is_last);
        endcase
    endfunction

    // Predict the output bytes caused by one accepted input byte
    function automatic void convert_byte(input logic [7:0] b, input logic is_last);
        step_results = 0;
        if (src_fmt > FMT_LE14 || tgt_fmt > FMT_LE14) return;
        pre_step  = PRE_NONE;
        post_step = POST_NONE;
        src_le    = (src_fmt == FMT_LE14);
        tgt_le    = (tgt_fmt == FMT_LE14);
        if (src_fmt <= FMT_BE16) begin
            if (tgt_fmt == FMT_LE16) post_step = POST_SWAP;
            else if (tgt_fmt >= FMT_BE14) post_step = POST_PACK;
        end else if (src_fmt == FMT_LE16) begin
            if (tgt_fmt <= FMT_BE16) begin
                post_step = POST_SWAP;
            end else if (tgt_fmt >= FMT_BE14) begin
                pre_step  = PRE_SWAP;
                post_step = POST_PACK;
            end
        end else begin
            if (tgt_fmt <= FMT_BE16) begin
                pre_step = PRE_UNPACK;
            end else if (tgt_fmt == FMT_LE16) begin
                pre_step  = PRE_UNPACK;
                post_step = POST_SWAP;
            end else if (tgt_fmt != src_fmt) begin
                post_step = POST_SWAP;
            end
        end
        case (pre_step)
            PRE_SWAP:   swap_byte(b, is_last);
            PRE_UNPACK: unpack_byte(b, is_last);
            default:    post_byte(b, is_last);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what);
        if (mismatch_count < MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Compare each accepted result byte with the oldest prediction
    always @(posedge aclk) begin : check_results
        ibyte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (bytes_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result byte %02h last %0b",
                                        m_tdata, m_tlast));
            end else begin
                want = bytes_due.pop_front();
                if (m_tdata !== want.data)
                    flag_mismatch($sformatf("out_byte %02h, expected %02h", m_tdata, want.data));
                if (m_tlast !== want.last)
                    flag_mismatch($sformatf("out_last %0b, expected %0b", m_tlast, want.last));
            end
        end
    end

    // Run guard
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side ready: forced low during a hold-off, else random
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one input byte after random idle cycles, hold until taken
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        do @(posedge aclk); while (!s_tready);
        convert_byte(b, is_last);
        items_sent++;
    endtask

    // Drop valid and wait until every predicted byte has come out
    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (bytes_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write one format register, then read it back
    task automatic write_format(input logic idx, input logic [2:0] val);
        logic [31:0] got;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {29'd0, val};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_SOURCE) src_fmt = val;
        else tgt_fmt = val;
        grp_fill   = 3'd0;
        held_valid = 1'b0;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {29'd0, val})
            flag_mismatch($sformatf("register %0d reads %08h, expected %0d", idx, got, val));
    endtask

    // Settle, then program both registers in random order
    task automatic set_conversion(input logic [2:0] src, input logic [2:0] tgt);
        wait_drain();
        if ($urandom_range(0, 1)) begin
            write_format(REG_SOURCE, src);
            write_format(REG_TARGET, tgt);
        end else begin
            write_format(REG_TARGET, tgt);
            write_format(REG_SOURCE, src);
        end
    endtask

    // Random frame; a truncated one leaves its tail pending
    task automatic send_frame(input int len, input logic truncated);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_byte(b, (i == len - 1) && !truncated);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, full and partial pack/unpack groups, odd swap count,
    // unknown format
    task automatic test_directed_cases();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        set_conversion(FMT_BYTES, FMT_BE14);
        repeat (7) send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
        set_conversion(FMT_BYTES, FMT_LE16);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h7F, 1'b1);
        set_conversion(FMT_BE14, FMT_BYTES);
        repeat (8) send_byte(8'hFF, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_byte(8'hA5, 1'b1);
        set_conversion(FMT_UNUSED_LAST, FMT_BYTES);
        send_byte(8'h5A, 1'b1);
    endtask

    // Every third format pair with random frames, some of them cut short
    task automatic test_all_conversions(input int phase);
        int start;
        for (int i = phase; i < 25; i += 3) begin
            set_conversion(3'(i / 5), 3'(i % 5));
            start = items_sent;
            while (items_sent - start < CONFIG_ITEMS)
                send_frame($urandom_range(1, 16), $urandom_range(0, 5) == 0);
        end
    endtask

    // Codes above the last format on either side swallow input
    task automatic test_unknown_formats();
        set_conversion(FMT_BYTES, FMT_UNUSED_FIRST);
        send_frame(4, 1'b0);
        set_conversion(FMT_LE14, FMT_UNUSED_LAST);
        send_frame(4, 1'b0);
        set_conversion(3'($urandom_range(FMT_UNUSED_FIRST, FMT_UNUSED_LAST)),
                       3'($urandom_range(FMT_UNUSED_FIRST, FMT_UNUSED_LAST)));
        send_frame(4, 1'b1);
    endtask

    // Hold the result side off while packing so the input backs up,
    // then pause mid frame until everything has drained
    task automatic test_output_backpressure();
        set_conversion(FMT_LE16, FMT_LE14);
        stall_left = 400;
        for (int f = 0; f < 5; f++) send_frame(7, 1'b0);
        send_frame(3, 1'b1);
        send_frame(3, 1'b1);
        wait_drain();
        send_frame(5, 1'b1);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();

        send_idle_pct = 25;
        recv_idle_pct = 79;
        test_all_conversions(0);

        send_idle_pct = 79;
        recv_idle_pct = 25;
        test_all_conversions(1);
        test_unknown_formats();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_all_conversions(2);
        test_output_backpressure();

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
